[hdl/hce_pkg.sv]
// ----------------------------------------------------------------------------
// hce_pkg: shared types and constants for the Huffman code table encoder
// Command codes, table entry layout and sequencer states.
// ----------------------------------------------------------------------------
package hce_pkg;

    localparam int CMD_W  = 2;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] value;
        logic [LEN_W-1:0]  length;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPEND,
        S_EMIT,
        S_FLUSH
    } t_state;

endpackage

[hdl/huffman_code_table_encoder.sv]
// ----------------------------------------------------------------------------
// huffman_code_table_encoder: table-driven Huffman encoder with MSB-first packer
// Code table in a single-port synchronous memory, bit accumulator drained one
// byte per cycle, while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
// Flow: an encode item is read from the table, appended to the accumulator in
//   S_APPEND and drained in S_EMIT through the output register. One item at a
//   time: the input stalls until the sequencer is idle again. An encode emits up
//   to (7 + MAX_CODE_BITS) / 8 bytes.
// Reset: per-entry valid bits clear, so every entry is treated as length zero;
//   accumulator and pending count clear. No memory clearing pass.
module huffman_code_table_encoder
    import hce_pkg::*;
#(
    parameter int SYMBOL_COUNT  = 256,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [CODE_W-1:0] i_code_value,
    input  logic [LEN_W-1:0]  i_code_length,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last_of_run
);

    localparam int IDX_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ACC_W  = MAX_CODE_BITS + 7;
    localparam int PEND_W = $clog2(MAX_CODE_BITS + 8);

    // code table memory and its valid bits
    t_entry            mem [SYMBOL_COUNT];
    logic              r_valid [SYMBOL_COUNT];
    t_entry            r_rd_data;
    logic              r_rd_valid;

    t_state            r_state, n_state;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [PEND_W-1:0] r_pend, n_pend;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;
    logic              w_load;

    logic              w_accept;
    logic              w_in_range;
    logic [IDX_W-1:0]  w_idx;
    logic [LEN_W-1:0]  w_len_sat;
    logic [CODE_W-1:0] w_mask;
    logic              w_out_free;
    logic [PEND_W-1:0] w_pend_m8;
    logic [3:0]        w_pad_sh;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_in_range = ({1'b0, i_symbol} < 9'(SYMBOL_COUNT));
    assign w_idx      = i_symbol[IDX_W-1:0];
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_len_sat = (i_code_length > LEN_W'(MAX_CODE_BITS)) ?
                       LEN_W'(MAX_CODE_BITS) : i_code_length;
    assign w_mask    = (w_len_sat >= LEN_W'(CODE_W)) ? '1 :
                       ((CODE_W'(1) << w_len_sat) - CODE_W'(1));

    assign w_pend_m8 = r_pend - PEND_W'(8);
    assign w_pad_sh  = 4'd8 - {1'b0, r_pend[2:0]};

    // table write or read, both on the accepting edge
    always_ff @(posedge i_clk) begin
        if (w_accept && w_in_range) begin
            if (i_command == CMD_WRITE) begin
                mem[w_idx] <= '{value: i_code_value & w_mask, length: w_len_sat};
            end
            r_rd_data <= mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SYMBOL_COUNT; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_rd_valid <= 1'b0;
        end else if (w_accept) begin
            if (i_command == CMD_WRITE && w_in_range) begin
                r_valid[w_idx] <= 1'b1;
            end
            r_rd_valid <= w_in_range && r_valid[w_idx];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_acc      = r_acc;
        n_pend     = r_pend;
        w_load     = 1'b0;
        n_out_byte = r_out_byte;
        n_out_last = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        CMD_ENCODE: n_state = S_APPEND;
                        CMD_FLUSH: begin
                            if (r_pend != '0) begin
                                n_state = S_FLUSH;
                            end else begin
                                n_acc = '0;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_APPEND: begin
                // an unwritten or out-of-range entry has length zero
                if (r_rd_valid && r_rd_data.length != '0) begin
                    n_acc  = (r_acc << r_rd_data.length) | ACC_W'(r_rd_data.value);
                    n_pend = r_pend + PEND_W'(r_rd_data.length);
                    n_state = (n_pend >= PEND_W'(8)) ? S_EMIT : S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    n_out_byte = BYTE_W'(r_acc >> w_pend_m8);
                    n_out_last = (w_pend_m8 < PEND_W'(8));
                    n_pend     = w_pend_m8;
                    if (n_out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    // zero padding on the right
                    n_out_byte = BYTE_W'(r_acc << w_pad_sh);
                    n_out_last = 1'b1;
                    n_acc      = '0;
                    n_pend     = '0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte <= n_out_byte;
            r_out_last <= n_out_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

    a_idle_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_pend < PEND_W'(8))
        else $error("pending bits not below 8 while idle");

    a_emit_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_pend >= PEND_W'(8))
        else $error("draining with less than one byte pending");

    a_flush_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_command == CMD_FLUSH && r_pend != '0 |=> r_state == S_FLUSH)
        else $error("flush with pending bits did not start");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && w_out_free && w_pend_m8 < PEND_W'(8)
        |=> r_state == S_IDLE && o_out_valid && o_last_of_run)
        else $error("last byte did not end the item");

endmodule
